// File: hdl/ggc_pkg.sv
// Shared constants for the greedy graph coloring unit.
// No dependencies; compiled first.
package ggc_pkg;

  // Fixed width of vertex and color fields on the ports
  localparam int FIELD_W = 7;

  // Default graph capacity and reset value of the vertex count register
  localparam int MAX_VERTICES_DEF = 64;
  localparam logic [FIELD_W-1:0] CNT_RESET = 7'd64;

  // Input word action codes
  localparam logic ACT_EDGE = 1'b0;
  localparam logic ACT_RUN  = 1'b1;

endpackage

// File: hdl/ggc_in_if.sv
// Input channel: edge-load or run command words.
// Depends on ggc_pkg.
interface ggc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        action;
  logic [ggc_pkg::FIELD_W-1:0] vertex_a;
  logic [ggc_pkg::FIELD_W-1:0] vertex_b;

  modport source (output valid, action, vertex_a, vertex_b, input ready);
  modport sink   (input valid, action, vertex_a, vertex_b, output ready);
endinterface

// File: hdl/ggc_out_if.sv
// Result channel: vertex and color pairs with a last marker.
// Depends on ggc_pkg.
interface ggc_out_if;
  logic                        valid;
  logic                        ready;
  logic [ggc_pkg::FIELD_W-1:0] vertex_id;
  logic [ggc_pkg::FIELD_W-1:0] color;
  logic                        last;

  modport source (output valid, vertex_id, color, last, input ready);
  modport sink   (input valid, vertex_id, color, last, output ready);
endinterface

// File: hdl/ggc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ggc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/greedy_graph_coloring_unit.sv
// Greedy first-fit graph coloring unit, top level.
// Depends on ggc_pkg, ggc_in_if, ggc_out_if and ggc_ram.
//
// Usage:
//   in_word  : action 0 adds the undirected edge vertex_a - vertex_b (ignored if an
//              endpoint is 0 or above the vertex count, or for a self-loop);
//              action 1 colors vertices 1..n and then emits n result words.
//   out_word : one (vertex_id, color) word per vertex in ascending order,
//              last set on vertex n.
//   cfg_we / cfg_wdata : vertex count register (reset 64), clamped to 1..MAX_VERTICES.
// Sequence:
//   An edge word passes through accept, row read and row write: one
//   read-modify-write of the adjacency RAM, which keeps each edge only in
//   the row of its higher endpoint.
//   A run colors each vertex u in turn: a row fetch, a walk over the earlier
//   vertices through the color RAM read port, a drain step (u > 0) and a scan
//   of the used-color flags. Results then leave one word at a time; the next
//   word is read only after out_word.ready has taken the current one.
// in_word.ready is high only when the unit is idle. A stalled receiver holds
// the current result word; the unit waits and resumes on ready.
// Reset clears the graph (per-row valid flags) and sets the count to 64.
module greedy_graph_coloring_unit #(
  parameter int MAX_VERTICES = ggc_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  ggc_in_if.sink                      in_word,
  ggc_out_if.source                   out_word,
  input  logic                        cfg_we,
  input  logic [ggc_pkg::FIELD_W-1:0] cfg_wdata
);

  localparam int FW = ggc_pkg::FIELD_W;
  localparam int VW = $clog2(MAX_VERTICES);
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int WW = (NW > FW) ? NW : FW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_EDGE_RD, ST_EDGE_WR, ST_ROW_RD, ST_ROW_LD, ST_SCAN,
    ST_DRAIN, ST_SEARCH, ST_EMIT_RD, ST_EMIT_LD, ST_EMIT_WAIT
  } state_t;

  state_t                  state_r;
  logic [FW-1:0]           cfg_r;
  logic [MAX_VERTICES-1:0] row_vld_r;
  logic [MAX_VERTICES-1:0] row_sh_r;
  logic [MAX_VERTICES-1:0] used_r;
  logic [VW-1:0]           u_r;
  logic [VW-1:0]           v_r;
  logic [VW-1:0]           hi_r;
  logic [VW-1:0]           lo_r;
  logic [FW-1:0]           c_r;
  logic                    pend_r;
  logic                    out_vld_r;
  logic [FW-1:0]           out_id_r;
  logic [FW-1:0]           out_clr_r;
  logic                    out_last_r;

  // Effective count and edge checks
  logic [WW-1:0] cnt_ext, n_c, a_ext, b_ext;
  logic [VW-1:0] nlast;
  logic          edge_ok;

  always_comb begin
    cnt_ext = WW'(cfg_r);
    if (cnt_ext == '0) begin
      n_c = WW'(1);
    end else if (cnt_ext > WW'(MAX_VERTICES)) begin
      n_c = WW'(MAX_VERTICES);
    end else begin
      n_c = cnt_ext;
    end
    nlast   = VW'(n_c - WW'(1));
    a_ext   = WW'(in_word.vertex_a);
    b_ext   = WW'(in_word.vertex_b);
    edge_ok = (a_ext != '0) && (a_ext <= n_c) && (b_ext != '0) && (b_ext <= n_c) &&
              (a_ext != b_ext);
  end

  // Adjacency RAM: row = higher endpoint, bit = lower endpoint
  logic                    adj_we;
  logic [VW-1:0]           adj_raddr;
  logic [MAX_VERTICES-1:0] adj_rdata, adj_wdata;

  assign adj_we    = (state_r == ST_EDGE_WR);
  assign adj_raddr = (state_r == ST_ROW_RD) ? u_r : hi_r;
  assign adj_wdata = (row_vld_r[hi_r] ? adj_rdata : '0) |
                     (MAX_VERTICES'(1) << lo_r);

  ggc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
    .clk  (clk),
    .we   (adj_we),
    .waddr(hi_r),
    .wdata(adj_wdata),
    .raddr(adj_raddr),
    .rdata(adj_rdata)
  );

  // Color RAM: written once per vertex per run, read while scanning and emitting
  logic          clr_we;
  logic [FW-1:0] clr_rdata;

  assign clr_we = (state_r == ST_SEARCH) && !used_r[0];

  ggc_ram #(.WIDTH(FW), .DEPTH(MAX_VERTICES)) u_clr_ram (
    .clk  (clk),
    .we   (clr_we),
    .waddr(u_r),
    .wdata(c_r),
    .raddr(v_r),
    .rdata(clr_rdata)
  );

  // Mark the color of an adjacent earlier vertex as taken
  logic [MAX_VERTICES-1:0] used_set;

  always_comb begin
    for (int k = 0; k < MAX_VERTICES; k++) begin
      used_set[k] = pend_r && (WW'(clr_rdata) == WW'(k + 1));
    end
  end

  assign in_word.ready      = (state_r == ST_IDLE);
  assign out_word.valid     = out_vld_r;
  assign out_word.vertex_id = out_id_r;
  assign out_word.color     = out_clr_r;
  assign out_word.last      = out_last_r;

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cfg_r     <= ggc_pkg::CNT_RESET;
      row_vld_r <= '0;
      pend_r    <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        cfg_r <= cfg_wdata;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_word.valid) begin
            if (in_word.action == ggc_pkg::ACT_RUN) begin
              u_r     <= '0;
              state_r <= ST_ROW_RD;
            end else if (edge_ok) begin
              if (a_ext > b_ext) begin
                hi_r <= VW'(a_ext - WW'(1));
                lo_r <= VW'(b_ext - WW'(1));
              end else begin
                hi_r <= VW'(b_ext - WW'(1));
                lo_r <= VW'(a_ext - WW'(1));
              end
              state_r <= ST_EDGE_RD;
            end
          end
        end
        ST_EDGE_RD: begin
          state_r <= ST_EDGE_WR;
        end
        ST_EDGE_WR: begin
          row_vld_r[hi_r] <= 1'b1;
          state_r         <= ST_IDLE;
        end
        ST_ROW_RD: begin
          state_r <= ST_ROW_LD;
        end
        ST_ROW_LD: begin
          row_sh_r <= row_vld_r[u_r] ? adj_rdata : '0;
          used_r   <= '0;
          pend_r   <= 1'b0;
          v_r      <= '0;
          c_r      <= FW'(1);
          state_r  <= (u_r == '0) ? ST_SEARCH : ST_SCAN;
        end
        // One earlier vertex per cycle; its color arrives in the next cycle
        ST_SCAN: begin
          used_r   <= used_r | used_set;
          pend_r   <= row_sh_r[0];
          row_sh_r <= row_sh_r >> 1;
          v_r      <= v_r + VW'(1);
          if (v_r == u_r - VW'(1)) begin
            state_r <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          used_r  <= used_r | used_set;
          pend_r  <= 1'b0;
          state_r <= ST_SEARCH;
        end
        // Lowest free color: shift flags down until a clear one shows up
        ST_SEARCH: begin
          if (used_r[0]) begin
            used_r <= used_r >> 1;
            c_r    <= c_r + FW'(1);
          end else if (u_r == nlast) begin
            v_r     <= '0;
            state_r <= ST_EMIT_RD;
          end else begin
            u_r     <= u_r + VW'(1);
            state_r <= ST_ROW_RD;
          end
        end
        ST_EMIT_RD: begin
          state_r <= ST_EMIT_LD;
        end
        ST_EMIT_LD: begin
          out_vld_r  <= 1'b1;
          out_id_r   <= FW'(v_r) + FW'(1);
          out_clr_r  <= clr_rdata;
          out_last_r <= (v_r == nlast);
          state_r    <= ST_EMIT_WAIT;
        end
        ST_EMIT_WAIT: begin
          if (out_word.ready) begin
            out_vld_r <= 1'b0;
            if (out_last_r) begin
              state_r <= ST_IDLE;
            end else begin
              v_r     <= v_r + VW'(1);
              state_r <= ST_EMIT_RD;
            end
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Checks
  a_no_accept_while_emitting: assert property (@(posedge clk) disable iff (!rst_n)
    in_word.ready |-> !out_word.valid)
    else $error("input accepted while a result is pending");

  a_last_is_vertex_n: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid && out_word.last |-> WW'(out_word.vertex_id) == n_c)
    else $error("last marker not on vertex n");

  a_color_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_SEARCH |-> WW'(c_r) <= WW'(u_r) + WW'(1))
    else $error("candidate color exceeds vertex position");

  a_color_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_word.valid |-> out_word.color != '0)
    else $error("zero color reported");

endmodule
